// File: rtl/hrbm_pkg.sv
// Package for the heart rate beat meter: widths, reset values, register
// indexes and the command/status structs between controller and datapath.
// No dependencies.
`default_nettype none

package hrbm_pkg;

	// Field widths
	localparam int SampleW  = 12;
	localparam int TimeW    = 32;
	localparam int MsW      = 16;
	localparam int RateW    = 8;
	localparam int QuoW     = 16;
	localparam int CfgIdxW  = 3;
	localparam int CfgDataW = 16;
	localparam int InDataW  = 48;
	localparam int OutDataW = 16;

	// Divider: 60000 fits in 16 bits, so 16 restoring steps give the quotient.
	localparam logic [QuoW-1:0] MsPerMinute = 16'd60000;
	localparam int DivSteps = QuoW;
	localparam int DivCntW  = $clog2(DivSteps);

	// Register reset values
	localparam logic [SampleW-1:0] ThresholdRst  = 12'd2048;
	localparam logic [MsW-1:0]     RefractoryRst = 16'd300;
	localparam logic [RateW-1:0]   MinRateRst    = 8'd40;
	localparam logic [RateW-1:0]   MaxRateRst    = 8'd200;
	localparam logic [MsW-1:0]     TimeoutRst    = 16'd3000;

	// Register indexes
	typedef enum logic [CfgIdxW-1:0] {
		CfgBeatThreshold = 3'd0,
		CfgRefractoryMs  = 3'd1,
		CfgMinRate       = 3'd2,
		CfgMaxRate       = 3'd3,
		CfgTimeoutMs     = 3'd4
	} cfg_idx_t;

	// Item kinds carried in tuser
	localparam logic OpSample = 1'b0;
	localparam logic OpReport = 1'b1;

	// Controller to datapath
	typedef struct packed {
		logic load;
		logic start_div;
		logic step_div;
		logic commit;
	} hrbm_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic need_div;
		logic div_last;
		logic out_free;
	} hrbm_sts_t;

endpackage

`default_nettype wire

// File: rtl/hrbm_div.sv
// Restoring radix-2 divider that computes 60000 / divisor, one bit a step.
// Depends on hrbm_pkg.
`default_nettype none

module hrbm_div (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         start,
	input  wire logic                         step,
	input  wire logic [hrbm_pkg::TimeW-1:0]   divisor,
	output logic      [hrbm_pkg::QuoW-1:0]    quotient,
	output logic                              last
);

	logic [hrbm_pkg::QuoW-1:0]    quo_q;
	logic [hrbm_pkg::QuoW-1:0]    rem_q;
	logic [hrbm_pkg::DivCntW-1:0] cnt_q;
	logic [hrbm_pkg::QuoW:0]      trial;
	logic                         fits;

	// The partial remainder never exceeds the partial dividend, so 16 bits hold it.
	assign trial = {rem_q, quo_q[hrbm_pkg::QuoW-1]};
	assign fits  = {{(hrbm_pkg::TimeW-hrbm_pkg::QuoW-1){1'b0}}, trial} >= divisor;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= '0;
		end else if (step) begin
			cnt_q <= cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= hrbm_pkg::MsPerMinute;
			rem_q <= '0;
		end else if (step) begin
			if (fits) begin
				rem_q <= trial[hrbm_pkg::QuoW-1:0] - divisor[hrbm_pkg::QuoW-1:0];
			end else begin
				rem_q <= trial[hrbm_pkg::QuoW-1:0];
			end
			quo_q <= {quo_q[hrbm_pkg::QuoW-2:0], fits};
		end
	end

	assign quotient = quo_q;
	assign last     = (cnt_q == hrbm_pkg::DivCntW'(hrbm_pkg::DivSteps - 1));

endmodule

`default_nettype wire

// File: rtl/hrbm_dp.sv
// Datapath of the beat meter: configuration registers, detector state, the
// captured item, the divider and the output register. Depends on hrbm_pkg, hrbm_div.
`default_nettype none

module hrbm_dp (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_we,
	input  wire logic [hrbm_pkg::CfgIdxW-1:0]      cfg_index,
	input  wire logic [hrbm_pkg::CfgDataW-1:0]     cfg_wdata,
	input  wire logic                              in_op,
	input  wire logic [hrbm_pkg::SampleW-1:0]      in_sample,
	input  wire logic [hrbm_pkg::TimeW-1:0]        in_now,
	input  wire hrbm_pkg::hrbm_cmd_t               cmd,
	output hrbm_pkg::hrbm_sts_t                    sts,
	output logic                                   out_valid,
	input  wire logic                              out_ready,
	output logic [hrbm_pkg::RateW-1:0]             out_rate,
	output logic                                   out_present,
	output logic                                   out_beat,
	output logic                                   out_changed
);

	// Configuration
	logic [hrbm_pkg::SampleW-1:0] thr_q;
	logic [hrbm_pkg::MsW-1:0]     refr_q;
	logic [hrbm_pkg::RateW-1:0]   min_q;
	logic [hrbm_pkg::RateW-1:0]   max_q;
	logic [hrbm_pkg::MsW-1:0]     tmo_q;

	// Detector state
	logic                         above_q;
	logic [hrbm_pkg::TimeW-1:0]   last_q;
	logic [hrbm_pkg::RateW-1:0]   cur_q;
	logic                         lost_q;
	logic [hrbm_pkg::RateW-1:0]   rep_q;

	// Captured item
	logic                         op_q;
	logic [hrbm_pkg::SampleW-1:0] sample_q;
	logic [hrbm_pkg::TimeW-1:0]   now_q;

	logic                         out_valid_q;

	logic [hrbm_pkg::TimeW-1:0]   diff;
	logic                         at_level;
	logic                         accept;
	logic                         need_div;
	logic [hrbm_pkg::QuoW-1:0]    quo;
	logic                         div_last;
	logic                         in_band;
	logic                         timed_out;
	logic [hrbm_pkg::RateW-1:0]   rate_nx;
	logic                         lost_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q  <= hrbm_pkg::ThresholdRst;
			refr_q <= hrbm_pkg::RefractoryRst;
			min_q  <= hrbm_pkg::MinRateRst;
			max_q  <= hrbm_pkg::MaxRateRst;
			tmo_q  <= hrbm_pkg::TimeoutRst;
		end else if (cfg_we) begin
			unique case (cfg_index)
				hrbm_pkg::CfgBeatThreshold: thr_q  <= cfg_wdata[hrbm_pkg::SampleW-1:0];
				hrbm_pkg::CfgRefractoryMs:  refr_q <= cfg_wdata;
				hrbm_pkg::CfgMinRate:       min_q  <= cfg_wdata[hrbm_pkg::RateW-1:0];
				hrbm_pkg::CfgMaxRate:       max_q  <= cfg_wdata[hrbm_pkg::RateW-1:0];
				hrbm_pkg::CfgTimeoutMs:     tmo_q  <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q     <= in_op;
			sample_q <= in_sample;
			now_q    <= in_now;
		end
	end

	// Time differences wrap modulo 2^32.
	assign diff     = now_q - last_q;
	assign at_level = (sample_q >= thr_q);
	assign accept   = (op_q == hrbm_pkg::OpSample) && !above_q && at_level &&
		(diff >= {{(hrbm_pkg::TimeW-hrbm_pkg::MsW){1'b0}}, refr_q});
	assign need_div = accept && (last_q != '0) && (diff != '0);

	hrbm_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.start_div),
		.step     (cmd.step_div),
		.divisor  (diff),
		.quotient (quo),
		.last     (div_last)
	);

	assign in_band =
		(quo >= {{(hrbm_pkg::QuoW-hrbm_pkg::RateW){1'b0}}, min_q}) &&
		(quo <= {{(hrbm_pkg::QuoW-hrbm_pkg::RateW){1'b0}}, max_q});

	// An accepted beat moves the last beat time to now, so only a sample
	// without a beat can time out.
	assign timed_out = !accept &&
		(diff > {{(hrbm_pkg::TimeW-hrbm_pkg::MsW){1'b0}}, tmo_q});

	always_comb begin
		rate_nx = cur_q;
		lost_nx = lost_q;
		if (need_div && in_band) begin
			rate_nx = quo[hrbm_pkg::RateW-1:0];
		end
		if (accept) begin
			lost_nx = 1'b0;
		end
		if (timed_out) begin
			rate_nx = '0;
			lost_nx = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			above_q <= 1'b0;
			last_q  <= '0;
			cur_q   <= '0;
			lost_q  <= 1'b1;
			rep_q   <= '0;
		end else if (cmd.commit) begin
			if (op_q == hrbm_pkg::OpReport) begin
				rep_q <= cur_q;
			end else begin
				above_q <= at_level;
				cur_q   <= rate_nx;
				lost_q  <= lost_nx;
				if (accept) begin
					last_q <= now_q;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			if (op_q == hrbm_pkg::OpReport) begin
				out_rate    <= cur_q;
				out_present <= !lost_q;
				out_beat    <= 1'b0;
				out_changed <= (cur_q != rep_q);
			end else begin
				out_rate    <= rate_nx;
				out_present <= !lost_nx;
				out_beat    <= accept;
				out_changed <= 1'b0;
			end
		end
	end

	assign out_valid     = out_valid_q;
	assign sts.need_div  = need_div;
	assign sts.div_last  = div_last;
	assign sts.out_free  = !out_valid_q || out_ready;

endmodule

`default_nettype wire

// File: rtl/hrbm_ctrl.sv
// Controller of the beat meter: sequences accept, evaluate, divide and commit.
// Depends on hrbm_pkg.
`default_nettype none

module hrbm_ctrl (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire hrbm_pkg::hrbm_sts_t   sts,
	output hrbm_pkg::hrbm_cmd_t        cmd
);

	typedef enum logic [1:0] {
		StIdle,
		StEval,
		StDivide,
		StCommit
	} state_t;

	state_t state_q;
	logic   ready_q;
	logic   take;

	assign take = in_valid && ready_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= StIdle;
			ready_q <= 1'b1;
		end else begin
			unique case (state_q)
				StIdle: begin
					if (take) begin
						state_q <= StEval;
						ready_q <= 1'b0;
					end
				end
				StEval: begin
					state_q <= sts.need_div ? StDivide : StCommit;
				end
				StDivide: begin
					if (sts.div_last) begin
						state_q <= StCommit;
					end
				end
				StCommit: begin
					if (sts.out_free) begin
						state_q <= StIdle;
						ready_q <= 1'b1;
					end
				end
				default: begin
					state_q <= StIdle;
					ready_q <= 1'b1;
				end
			endcase
		end
	end

	assign in_ready      = ready_q;
	assign cmd.load      = take;
	assign cmd.start_div = (state_q == StEval) && sts.need_div;
	assign cmd.step_div  = (state_q == StDivide);
	assign cmd.commit    = (state_q == StCommit) && sts.out_free;

endmodule

`default_nettype wire

// File: rtl/heart_rate_beat_meter.sv
// Top level of the heart rate beat meter: stream ports, controller and datapath.
// Depends on hrbm_pkg, hrbm_ctrl, hrbm_dp (and hrbm_div below it).
`default_nettype none

// The meter takes one item at a time. A sample item (tuser low) carries a
// 12-bit converter value and a wrapping millisecond timestamp; a rising
// crossing of the threshold that comes at least the refractory time after
// the previous accepted beat is a beat, and 60000 divided by the beat
// interval becomes the rate when it lies inside the min..max band. When
// no beat has been seen for longer than the timeout, the rate drops to
// zero and the signal is reported lost. A report item (tuser high)
// returns the current rate and flags whether it differs from the rate
// returned by the previous report. Every item gives exactly one result.
// An item that needs a new rate passes from acceptance through evaluate,
// the sixteen steps of the radix-2 divider, one quotient bit per cycle,
// and commit into the result register; every other item goes from
// evaluate straight to commit. The input is taken again as soon as the
// result is in the output register, so a finished result may wait there
// while the next item is worked on. Configuration registers are written
// through cfg_we, cfg_index and cfg_wdata; the user must write them only
// while no item is in flight, as the block does not enforce this. Indexes
// 0 to 4 are the threshold, refractory time, minimum rate, maximum rate
// and timeout, and other indexes are ignored.

module heart_rate_beat_meter (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_we,
	input  wire logic [hrbm_pkg::CfgIdxW-1:0]      cfg_index,
	input  wire logic [hrbm_pkg::CfgDataW-1:0]     cfg_wdata,
	input  wire logic                              s_axis_tvalid,
	output logic                                   s_axis_tready,
	// sample [11:0], now_ms [43:12], zero [47:44]
	input  wire logic [hrbm_pkg::InDataW-1:0]      s_axis_tdata,
	// operation
	input  wire logic                              s_axis_tuser,
	output logic                                   m_axis_tvalid,
	input  wire logic                              m_axis_tready,
	// rate_bpm [7:0], signal_present [8], beat_accepted [9],
	// rate_changed [10], zero [15:11]
	output logic [hrbm_pkg::OutDataW-1:0]          m_axis_tdata
);

	hrbm_pkg::hrbm_cmd_t          cmd;
	hrbm_pkg::hrbm_sts_t          sts;
	logic [hrbm_pkg::RateW-1:0]   out_rate;
	logic                         out_present;
	logic                         out_beat;
	logic                         out_changed;

	// Sequencing of one item at a time.
	hrbm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// Registers, detector state, divider and the result register.
	hrbm_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_wdata   (cfg_wdata),
		.in_op       (s_axis_tuser),
		.in_sample   (s_axis_tdata[hrbm_pkg::SampleW-1:0]),
		.in_now      (s_axis_tdata[hrbm_pkg::SampleW +: hrbm_pkg::TimeW]),
		.cmd         (cmd),
		.sts         (sts),
		.out_valid   (m_axis_tvalid),
		.out_ready   (m_axis_tready),
		.out_rate    (out_rate),
		.out_present (out_present),
		.out_beat    (out_beat),
		.out_changed (out_changed)
	);

	// The unused top bits of the result are zero.
	assign m_axis_tdata = {
		{(hrbm_pkg::OutDataW-hrbm_pkg::RateW-3){1'b0}},
		out_changed, out_beat, out_present, out_rate
	};

endmodule

`default_nettype wire

// File: rtl/hrbm_checker.sv
// Port-level checks for the heart rate beat meter, bound to the top level.
// Depends on heart_rate_beat_meter.
`default_nettype none

module hrbm_props (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_axis_tvalid,
	input wire logic        s_axis_tready,
	input wire logic        m_axis_tvalid,
	input wire logic        m_axis_tready,
	input wire logic [15:0] m_axis_tdata
);

	// A held result keeps its contents until taken.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result changed while stalled");

	// Only one item is worked on at a time.
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("input taken again before the item finished");

	// A lost signal carries no rate.
	a_lost_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tdata[8] |-> m_axis_tdata[7:0] == 8'd0)
		else $error("nonzero rate with the signal lost");

	// An accepted beat means the signal is present.
	a_beat_present: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[9] |-> m_axis_tdata[8])
		else $error("beat accepted while the signal is lost");

	// A beat comes only from a sample, a change flag only from a report.
	a_kind: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !(m_axis_tdata[9] && m_axis_tdata[10]))
		else $error("beat and rate change flagged in one result");

endmodule

bind heart_rate_beat_meter hrbm_props u_hrbm_props (.*);

`default_nettype wire
